/* hw/rtl/quaternion_smallest_three_codec_macros.svh */
// ----------------------------------------------------------------------------
// Quaternion smallest-three codec assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SMALLEST_THREE_CODEC_MACROS_SVH
`define QUATERNION_SMALLEST_THREE_CODEC_MACROS_SVH

// same-cycle implication
`define QSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/qsc_pkg.sv */
// ----------------------------------------------------------------------------
// qsc_pkg
// Types and fixed constants of the quaternion smallest-three codec.
// ----------------------------------------------------------------------------
package qsc_pkg;

  localparam int unsigned COMP_BITS = 16;
  localparam int unsigned FRAC_BITS = COMP_BITS - 1;

  // sqrt2 in Q24 and 1/sqrt2 in Q30
  localparam logic [24:0] SQRT2_Q24    = 25'd23726566;
  localparam logic [29:0] INVSQRT2_Q30 = 30'd759250125;

  localparam int unsigned VAL_W  = 30;              // rebuilt component, Q0.30 magnitude
  localparam int unsigned SQ_W   = 62;              // sums of squares, Q.60
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned QUO_W  = FRAC_BITS + 1;   // output magnitude before saturation

  // input word to result strobe, in cycles
  localparam int unsigned PIPE_LAT = 6 + ROOT_W + 2 + ROOT_W + 1 + QUO_W + 1;

  typedef enum logic {
    OP_PACK   = 1'b0,
    OP_UNPACK = 1'b1
  } qsc_op_e;

  typedef struct packed {
    qsc_op_e                     op;
    logic signed [COMP_BITS-1:0] comp_x;
    logic signed [COMP_BITS-1:0] comp_y;
    logic signed [COMP_BITS-1:0] comp_z;
    logic signed [COMP_BITS-1:0] comp_w;
    logic [31:0]                 packed_in;
  } qsc_in_t;

  typedef struct packed {
    logic [31:0]                 packed_out;
    logic signed [COMP_BITS-1:0] out_x;
    logic signed [COMP_BITS-1:0] out_y;
    logic signed [COMP_BITS-1:0] out_z;
    logic signed [COMP_BITS-1:0] out_w;
  } qsc_out_t;

endpackage

/* hw/rtl/qsc_isqrt.sv */
// ----------------------------------------------------------------------------
// qsc_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module qsc_isqrt #(
  parameter int unsigned IN_W   = 62,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [IN_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [IN_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned STAGES = IN_W / 2;

  logic [STAGES-1:0] vld_q;
  logic [IN_W-1:0]   rem_q  [STAGES];
  logic [IN_W-1:0]   res_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic [IN_W-1:0] BIT_K = IN_W'(1) << (IN_W - 2 - 2 * k);

    logic              vld_in;
    logic [IN_W-1:0]   rem_in;
    logic [IN_W-1:0]   res_in;
    logic [SIDE_W-1:0] side_in;
    logic [IN_W:0]     trial;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT_K};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      if ({1'b0, rem_in} >= trial) begin
        rem_q[k] <= rem_in - trial[IN_W-1:0];
        res_q[k] <= (res_in >> 1) + BIT_K;
      end else begin
        rem_q[k] <= rem_in;
        res_q[k] <= res_in >> 1;
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = res_q[STAGES-1][IN_W/2-1:0];
  assign side_o  = side_q[STAGES-1];

endmodule

/* hw/rtl/qsc_div.sv */
// ----------------------------------------------------------------------------
// qsc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qsc_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 16
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned POS = Q_W - 1 - k;

    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [CMP_W-1:0] shifted;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = CMP_W'(den_in) << POS;

    always_ff @(posedge clk_i) begin
      den_q[k] <= den_in;
      if (CMP_W'(rem_in) >= shifted) begin
        rem_q[k] <= rem_in - shifted[NUM_W-1:0];
        quo_q[k] <= quo_in | (Q_W'(1) << POS);
      end else begin
        rem_q[k] <= rem_in;
        quo_q[k] <= quo_in;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

/* hw/rtl/quaternion_smallest_three_codec.sv */
// ----------------------------------------------------------------------------
// quaternion_smallest_three_codec
// Packs a Q1.15 unit quaternion into a smallest-three word, or unpacks one.
// ----------------------------------------------------------------------------
//  channel | signals                  | rule
//  --------+--------------------------+------------------------------------
//  in      | start, busy, in_i        | word taken when start && !busy
//  result  | done_o, res_o            | word shown for one cycle with done_o
//
//  A word can enter every cycle; busy stays low.
//  On its way to the result each word passes through the two 31-stage square
//  root pipelines and the 16-stage divide lanes.
//  Reset clears the valid bits only; nothing else needs clearing.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_codec
  import qsc_pkg::*;
#(
  parameter int unsigned CODE_BITS = 10
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  qsc_in_t  in_i,
  output logic     done_o,
  output qsc_out_t res_o
);

  localparam logic [CODE_BITS-1:0] CODE_MAX = '1;
  localparam logic [CODE_BITS-1:0] HALF_MAX = CODE_MAX >> 1;

  // pack path widths
  localparam int unsigned X_W    = COMP_BITS + 1;
  localparam int unsigned T_W    = X_W + 26;
  localparam int unsigned LIM_SH = FRAC_BITS + 24;
  localparam int unsigned U_W    = FRAC_BITS + 26;
  localparam int unsigned CF_W   = U_W + CODE_BITS + 1;
  localparam logic signed [T_W-1:0] SQRT2_S = T_W'(SQRT2_Q24);
  localparam logic signed [T_W-1:0] LIM     = T_W'(1) << LIM_SH;

  // unpack path widths
  localparam int unsigned A_W   = CODE_BITS + VAL_W;
  localparam int unsigned TERMS = (A_W + CODE_BITS - 1) / CODE_BITS;
  localparam int unsigned S_W   = A_W + 1;
  localparam int unsigned Q0_W  = S_W - CODE_BITS;
  localparam int unsigned NUM_W = ROOT_W + QUO_W + 1;
  localparam int unsigned DEN_W = ROOT_W + 1;
  localparam logic [SQ_W-1:0] ONE_Q60 = SQ_W'(1) << (2 * VAL_W);

  typedef struct packed {
    qsc_op_e                 op;
    logic [31:0]             pword;
    logic [1:0]              lg;
    logic [2:0]              neg;
    logic [2:0][VAL_W-1:0]   val;
    logic [SQ_W-1:0]         sum;
  } root_side_t;

  typedef struct packed {
    qsc_op_e                 op;
    logic [31:0]             pword;
    logic [3:0]              neg;
    logic [3:0][ROOT_W-1:0]  mag;
  } norm_side_t;

  typedef struct packed {
    qsc_op_e     op;
    logic [31:0] pword;
    logic [3:0]  neg;
    logic        zero;
  } out_side_t;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------- stage 1
  logic signed [COMP_BITS-1:0] cin [4];
  logic [3:0][X_W-1:0]         ax;
  logic [1:0]                  plg_d;
  logic [2:0][X_W-1:0]         px_d;
  logic [2:0][CODE_BITS-1:0]   umag;
  logic [2:0]                  uneg_d;
  logic [2:0][A_W-1:0]         ua_d;

  assign cin[0] = in_i.comp_x;
  assign cin[1] = in_i.comp_y;
  assign cin[2] = in_i.comp_z;
  assign cin[3] = in_i.comp_w;

  always_comb begin
    logic signed [X_W-1:0] cx [4];
    logic [CODE_BITS-1:0]  code;
    logic [CODE_BITS:0]    two;
    logic                  neg;
    int unsigned           idx;
    for (int i = 0; i < 4; i++) begin
      cx[i] = X_W'(cin[i]);
      ax[i] = cx[i][X_W-1] ? X_W'(-cx[i]) : X_W'(cx[i]);
    end
    // lower index wins a tie
    plg_d = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (ax[i] > ax[plg_d]) plg_d = 2'(i);
    end
    neg = cx[plg_d][X_W-1];
    for (int k = 0; k < 3; k++) begin
      idx     = (k >= int'(plg_d)) ? k + 1 : k;
      px_d[k] = neg ? X_W'(-cx[idx]) : X_W'(cx[idx]);
    end
    for (int k = 0; k < 3; k++) begin
      code = in_i.packed_in[k*CODE_BITS +: CODE_BITS];
      two  = {code, 1'b0};
      if (two >= {1'b0, CODE_MAX}) begin
        umag[k]   = CODE_BITS'(two - {1'b0, CODE_MAX});
        uneg_d[k] = 1'b0;
      end else begin
        umag[k]   = CODE_BITS'({1'b0, CODE_MAX} - two);
        uneg_d[k] = 1'b1;
      end
      ua_d[k] = A_W'(umag[k]) * A_W'(INVSQRT2_Q30) + A_W'(HALF_MAX);
    end
  end

  logic                      s1_vld_q;
  qsc_op_e                   s1_op_q;
  logic [1:0]                s1_plg_q, s1_ulg_q;
  logic [2:0][X_W-1:0]       s1_px_q;
  logic [2:0]                s1_uneg_q;
  logic [2:0][A_W-1:0]       s1_ua_q;

  // ---------------------------------------------------------------- stage 2
  logic [2:0][T_W-1:0]  pt_d;
  logic [2:0][Q0_W-1:0] uq0_d;

  always_comb begin
    logic [S_W-1:0] s;
    for (int k = 0; k < 3; k++) begin
      pt_d[k] = T_W'($signed(s1_px_q[k])) * SQRT2_S;
      // divide by 2^B-1 as a sum of shifts; low by at most one
      s = '0;
      for (int t = 0; t < TERMS; t++) begin
        s = s + S_W'(s1_ua_q[k] >> (t * CODE_BITS));
      end
      uq0_d[k] = Q0_W'(s >> CODE_BITS);
    end
  end

  logic                      s2_vld_q;
  qsc_op_e                   s2_op_q;
  logic [1:0]                s2_plg_q, s2_ulg_q;
  logic [2:0][T_W-1:0]       s2_pt_q;
  logic [2:0]                s2_uneg_q;
  logic [2:0][A_W-1:0]       s2_ua_q;
  logic [2:0][Q0_W-1:0]      s2_uq0_q;

  // ---------------------------------------------------------------- stage 3
  logic [31:0]           pword_d;
  logic [2:0][VAL_W-1:0] uv_d;

  always_comb begin
    logic signed [T_W-1:0] tc;
    logic [U_W-1:0]        u;
    logic [CF_W-1:0]       cf;
    logic [S_W-1:0]        r;
    pword_d        = '0;
    pword_d[31:30] = s2_plg_q;
    for (int k = 0; k < 3; k++) begin
      tc = $signed(s2_pt_q[k]);
      if (tc > LIM) tc = LIM;
      if (tc < -LIM) tc = -LIM;
      u  = U_W'(tc + LIM);
      // never exceeds CODE_MAX, so no clamp
      cf = (CF_W'(u) << CODE_BITS) - CF_W'(u) + (CF_W'(1) << LIM_SH);
      pword_d[k*CODE_BITS +: CODE_BITS] = CODE_BITS'(cf >> (LIM_SH + 1));
      r = S_W'(s2_ua_q[k]) + S_W'(s2_uq0_q[k]) - (S_W'(s2_uq0_q[k]) << CODE_BITS);
      uv_d[k] = (r >= S_W'(CODE_MAX)) ? VAL_W'(s2_uq0_q[k] + 1'b1) : VAL_W'(s2_uq0_q[k]);
    end
  end

  logic                  s3_vld_q;
  qsc_op_e               s3_op_q;
  logic [31:0]           s3_pword_q;
  logic [1:0]            s3_ulg_q;
  logic [2:0]            s3_uneg_q;
  logic [2:0][VAL_W-1:0] s3_uv_q;

  // ---------------------------------------------------------------- stage 4
  logic [2:0][2*VAL_W-1:0] sq_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = s3_uv_q[k] * s3_uv_q[k];
    end
  end

  logic                    s4_vld_q;
  qsc_op_e                 s4_op_q;
  logic [31:0]             s4_pword_q;
  logic [1:0]              s4_ulg_q;
  logic [2:0]              s4_uneg_q;
  logic [2:0][VAL_W-1:0]   s4_uv_q;
  logic [2:0][2*VAL_W-1:0] s4_sq_q;

  // ---------------------------------------------------------------- stage 5
  logic       s5_vld_q;
  root_side_t s5_side_q;

  // ---------------------------------------------------------------- stage 6
  logic       s6_vld_q;
  logic [SQ_W-1:0] s6_rad_q;
  root_side_t s6_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= in_i.op;
    s1_plg_q  <= plg_d;
    s1_px_q   <= px_d;
    s1_ulg_q  <= in_i.packed_in[31:30];
    s1_uneg_q <= uneg_d;
    s1_ua_q   <= ua_d;

    s2_op_q   <= s1_op_q;
    s2_plg_q  <= s1_plg_q;
    s2_pt_q   <= pt_d;
    s2_ulg_q  <= s1_ulg_q;
    s2_uneg_q <= s1_uneg_q;
    s2_ua_q   <= s1_ua_q;
    s2_uq0_q  <= uq0_d;

    s3_op_q    <= s2_op_q;
    s3_pword_q <= pword_d;
    s3_ulg_q   <= s2_ulg_q;
    s3_uneg_q  <= s2_uneg_q;
    s3_uv_q    <= uv_d;

    s4_op_q    <= s3_op_q;
    s4_pword_q <= s3_pword_q;
    s4_ulg_q   <= s3_ulg_q;
    s4_uneg_q  <= s3_uneg_q;
    s4_uv_q    <= s3_uv_q;
    s4_sq_q    <= sq_d;

    s5_side_q.op    <= s4_op_q;
    s5_side_q.pword <= s4_pword_q;
    s5_side_q.lg    <= s4_ulg_q;
    s5_side_q.neg   <= s4_uneg_q;
    s5_side_q.val   <= s4_uv_q;
    s5_side_q.sum   <= SQ_W'(s4_sq_q[0]) + SQ_W'(s4_sq_q[1]) + SQ_W'(s4_sq_q[2]);

    // an over-unit sum drops the largest to zero
    s6_side_q <= s5_side_q;
    s6_rad_q  <= (s5_side_q.sum < ONE_Q60) ? ONE_Q60 - s5_side_q.sum : '0;
  end

  // ----------------------------------------------------- largest component
  logic              r1_vld;
  logic [ROOT_W-1:0] r1_root;
  root_side_t        r1_side;

  qsc_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W ($bits(root_side_t))
  ) u_isqrt_lg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .rad_i   (s6_rad_q),
    .side_i  (s6_side_q),
    .valid_o (r1_vld),
    .root_o  (r1_root),
    .side_o  (r1_side)
  );

  // ---------------------------------------------------------------- stage 7
  logic              s7_vld_q;
  logic [ROOT_W-1:0] s7_l_q;
  logic [SQ_W-1:0]   s7_lsq_q;
  root_side_t        s7_side_q;

  // ---------------------------------------------------------------- stage 8
  logic            s8_vld_q;
  logic [SQ_W-1:0] s8_norm2_q;
  norm_side_t      s8_side_q;
  norm_side_t      lane_d;

  always_comb begin
    int unsigned k;
    lane_d.op    = s7_side_q.op;
    lane_d.pword = s7_side_q.pword;
    for (int i = 0; i < 4; i++) begin
      k = (i > int'(s7_side_q.lg)) ? i - 1 : i;
      if (i == int'(s7_side_q.lg)) begin
        lane_d.mag[i] = s7_l_q;
        lane_d.neg[i] = 1'b0;
      end else begin
        lane_d.mag[i] = ROOT_W'(s7_side_q.val[k[1:0]]);
        lane_d.neg[i] = s7_side_q.neg[k[1:0]];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
    end else begin
      s7_vld_q <= r1_vld;
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_l_q     <= r1_root;
    s7_lsq_q   <= r1_root * r1_root;
    s7_side_q  <= r1_side;
    s8_norm2_q <= s7_side_q.sum + s7_lsq_q;
    s8_side_q  <= lane_d;
  end

  // ------------------------------------------------------------------ norm
  logic              r2_vld;
  logic [ROOT_W-1:0] r2_norm;
  norm_side_t        r2_side;

  qsc_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W ($bits(norm_side_t))
  ) u_isqrt_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s8_vld_q),
    .rad_i   (s8_norm2_q),
    .side_i  (s8_side_q),
    .valid_o (r2_vld),
    .root_o  (r2_norm),
    .side_o  (r2_side)
  );

  // ---------------------------------------------------------------- stage 9
  logic                  s9_vld_q;
  logic [3:0][NUM_W-1:0] s9_num_q;
  logic [DEN_W-1:0]      s9_den_q;
  out_side_t             s9_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else begin
      s9_vld_q <= r2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      s9_num_q[i] <= (NUM_W'(r2_side.mag[i]) << QUO_W) + NUM_W'(r2_norm);
    end
    s9_den_q        <= DEN_W'(r2_norm) << 1;
    s9_side_q.op    <= r2_side.op;
    s9_side_q.pword <= r2_side.pword;
    s9_side_q.neg   <= r2_side.neg;
    s9_side_q.zero  <= (r2_norm == '0);
  end

  // --------------------------------------------------------- divide lanes
  logic [3:0][QUO_W-1:0] quo;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qsc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .Q_W   (QUO_W)
    ) u_div (
      .clk_i (clk_i),
      .num_i (s9_num_q[i]),
      .den_i (s9_den_q),
      .quo_o (quo[i])
    );
  end

  // hold side data alongside the divide lanes
  logic [QUO_W-1:0] dvld_q;
  out_side_t        dside_q [QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvld_q <= '0;
    end else begin
      dvld_q <= {dvld_q[QUO_W-2:0], s9_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dside_q[0] <= s9_side_q;
    for (int j = 1; j < QUO_W; j++) begin
      dside_q[j] <= dside_q[j-1];
    end
  end

  // --------------------------------------------------------------- output
  out_side_t                          fin;
  logic [3:0][COMP_BITS-1:0]          comp_d;
  qsc_out_t                           res_d;

  assign fin = dside_q[QUO_W-1];

  always_comb begin
    logic [COMP_BITS-1:0] q;
    for (int i = 0; i < 4; i++) begin
      q = COMP_BITS'(quo[i]);
      if (fin.zero) begin
        comp_d[i] = '0;
      end else if (fin.neg[i]) begin
        comp_d[i] = -q;
      end else if (q[COMP_BITS-1]) begin
        // saturate 1.0 and above to the largest positive value
        comp_d[i] = {1'b0, {(COMP_BITS-1){1'b1}}};
      end else begin
        comp_d[i] = q;
      end
    end
    if (fin.op == OP_PACK) begin
      res_d.packed_out = fin.pword;
      res_d.out_x      = '0;
      res_d.out_y      = '0;
      res_d.out_z      = '0;
      res_d.out_w      = '0;
    end else begin
      res_d.packed_out = '0;
      res_d.out_x      = comp_d[0];
      res_d.out_y      = comp_d[1];
      res_d.out_z      = comp_d[2];
      res_d.out_w      = comp_d[3];
    end
  end

  logic     done_q;
  qsc_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvld_q[QUO_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* hw/rtl/qsc_checker.sv */
// ----------------------------------------------------------------------------
// qsc_checker
// Port-level timing and result checks for the smallest-three codec.
// ----------------------------------------------------------------------------
`include "quaternion_smallest_three_codec_macros.svh"

module qsc_port_assert
  import qsc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input qsc_out_t res_o
);

  // every accepted word comes out with a result strobe, and no strobe comes without one
  `QSC_ASSERT_NEXT(a_lat_fwd, start && !busy, ##(PIPE_LAT-1) done_o, "result strobe missing")
  `QSC_ASSERT_NOW(a_lat_back, done_o, $past(start && !busy, PIPE_LAT), "result without word")

  // a packed word never carries component values alongside it
  `QSC_ASSERT_NOW(a_pack_zero, done_o && res_o.packed_out != '0,
    res_o.out_x == '0 && res_o.out_y == '0 && res_o.out_z == '0 && res_o.out_w == '0,
    "components set on pack result")

endmodule

bind quaternion_smallest_three_codec qsc_port_assert u_qsc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
